// ----- hw/rtl/scct_pkg.sv -----
// shared constants and types for the sector cache clock tag engine
// used by sector_cache_clock_tags_top; no other dependencies
`timescale 1ns / 1ps

package scct_pkg;

  localparam int unsigned Entries   = 64;
  localparam int unsigned SlotW     = $clog2(Entries);
  localparam int unsigned SectorW   = 32;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(Entries - 1);

  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpFlush = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StLookup,
    StCompare,
    StHit,
    StSweep,
    StVictim,
    StFlStart,
    StFlScan,
    StFlEmit
  } state_e;

  typedef logic [SlotW-1:0]   slot_t;
  typedef logic [SectorW-1:0] sector_t;
  typedef logic [Entries-1:0] mask_t;

endpackage

// ----- hw/rtl/sector_cache_clock_tags_top.sv -----
// tag and clock-replacement engine for a fully associative write-back sector cache
// depends on scct_pkg; holds the tag memory, per-entry mark bits and the sequencer
// the tag scan goes through the single tag memory port, reading and comparing each
// valid entry in turn, and the clock sweep checks one entry per cycle; flush emits
// one beat per dirty entry, or a single beat when none is dirty; one item at a time.
// reset clears all marks and the hand
`timescale 1ns / 1ps

module sector_cache_clock_tags_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [scct_pkg::SectorW-1:0] sector_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [scct_pkg::SlotW-1:0] slot_o,
  output logic                       hit_o,
  output logic                       fill_needed_o,
  output logic                       writeback_needed_o,
  output logic [scct_pkg::SectorW-1:0] writeback_sector_o,
  output logic                       last_o
);

  scct_pkg::state_e  state_q, state_d;
  scct_pkg::slot_t   idx_q, idx_d, idx_nxt;
  scct_pkg::slot_t   hand_q, hand_d;
  scct_pkg::sector_t sector_q, sector_d;
  logic              wr_q, wr_d;
  scct_pkg::mask_t   valid_q, valid_d;
  scct_pkg::mask_t   dirty_q, dirty_d;
  scct_pkg::mask_t   acc_q, acc_d;
  scct_pkg::mask_t   pending;

  logic              out_valid_q, out_valid_d;
  scct_pkg::slot_t   slot_q, slot_d;
  logic              hit_q, hit_d;
  logic              fill_q, fill_d;
  logic              wb_q, wb_d;
  scct_pkg::sector_t wbs_q, wbs_d;
  logic              last_q, last_d;
  logic              out_free;

  // tag memory
  scct_pkg::sector_t tag_mem [scct_pkg::Entries];
  scct_pkg::sector_t tag_rdata_q;
  logic              mem_re, mem_we;
  scct_pkg::slot_t   mem_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_addr] <= sector_q;
    end
    if (mem_re) begin
      tag_rdata_q <= tag_mem[mem_addr];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign idx_nxt  = (idx_q == scct_pkg::LastSlot) ? '0 : idx_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    hand_d      = hand_q;
    sector_d    = sector_q;
    wr_d        = wr_q;
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    slot_d      = slot_q;
    hit_d       = hit_q;
    fill_d      = fill_q;
    wb_d        = wb_q;
    wbs_d       = wbs_q;
    last_d      = last_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = idx_q;
    pending     = valid_q & dirty_q;
    pending[idx_q] = 1'b0;

    case (state_q)
      scct_pkg::StIdle: begin
        if (in_valid_i) begin
          sector_d = sector_i;
          wr_d     = (operation_i == scct_pkg::OpWrite);
          idx_d    = '0;
          if (operation_i == scct_pkg::OpRead || operation_i == scct_pkg::OpWrite) begin
            state_d = scct_pkg::StLookup;
          end else if (operation_i == scct_pkg::OpFlush) begin
            state_d = scct_pkg::StFlStart;
          end
        end
      end
      scct_pkg::StLookup: begin
        if (valid_q[idx_q]) begin
          mem_re  = 1'b1;
          state_d = scct_pkg::StCompare;
        end else if (idx_q == scct_pkg::LastSlot) begin
          idx_d   = hand_q;
          state_d = scct_pkg::StSweep;
        end else begin
          idx_d = idx_nxt;
        end
      end
      scct_pkg::StCompare: begin
        if (tag_rdata_q == sector_q) begin
          state_d = scct_pkg::StHit;
        end else if (idx_q == scct_pkg::LastSlot) begin
          idx_d   = hand_q;
          state_d = scct_pkg::StSweep;
        end else begin
          idx_d   = idx_nxt;
          state_d = scct_pkg::StLookup;
        end
      end
      scct_pkg::StHit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          slot_d      = idx_q;
          hit_d       = 1'b1;
          fill_d      = 1'b0;
          wb_d        = 1'b0;
          wbs_d       = '0;
          last_d      = 1'b1;
          acc_d[idx_q] = 1'b1;
          if (wr_q) begin
            dirty_d[idx_q] = 1'b1;
          end
          state_d = scct_pkg::StIdle;
        end
      end
      scct_pkg::StSweep: begin
        if (!valid_q[idx_q] || !acc_q[idx_q]) begin
          hand_d  = idx_nxt;
          mem_re  = 1'b1;
          state_d = scct_pkg::StVictim;
        end else begin
          acc_d[idx_q] = 1'b0;
          idx_d        = idx_nxt;
        end
      end
      scct_pkg::StVictim: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          slot_d      = idx_q;
          hit_d       = 1'b0;
          fill_d      = 1'b1;
          wb_d        = valid_q[idx_q] && dirty_q[idx_q];
          wbs_d       = (valid_q[idx_q] && dirty_q[idx_q]) ? tag_rdata_q : '0;
          last_d      = 1'b1;
          mem_we      = 1'b1;
          valid_d[idx_q] = 1'b1;
          dirty_d[idx_q] = wr_q;
          acc_d[idx_q]   = 1'b1;
          state_d = scct_pkg::StIdle;
        end
      end
      scct_pkg::StFlStart: begin
        if ((valid_q & dirty_q) == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            slot_d      = '0;
            hit_d       = 1'b0;
            fill_d      = 1'b0;
            wb_d        = 1'b0;
            wbs_d       = '0;
            last_d      = 1'b1;
            state_d     = scct_pkg::StIdle;
          end
        end else begin
          idx_d   = '0;
          state_d = scct_pkg::StFlScan;
        end
      end
      scct_pkg::StFlScan: begin
        if (valid_q[idx_q] && dirty_q[idx_q]) begin
          mem_re  = 1'b1;
          state_d = scct_pkg::StFlEmit;
        end else if (idx_q == scct_pkg::LastSlot) begin
          state_d = scct_pkg::StIdle;
        end else begin
          idx_d = idx_nxt;
        end
      end
      scct_pkg::StFlEmit: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          slot_d         = idx_q;
          hit_d          = 1'b0;
          fill_d         = 1'b0;
          wb_d           = 1'b1;
          wbs_d          = tag_rdata_q;
          last_d         = (pending == '0);
          dirty_d[idx_q] = 1'b0;
          if (pending == '0 || idx_q == scct_pkg::LastSlot) begin
            state_d = scct_pkg::StIdle;
          end else begin
            idx_d   = idx_nxt;
            state_d = scct_pkg::StFlScan;
          end
        end
      end
      default: begin
        state_d = scct_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scct_pkg::StIdle;
      idx_q       <= '0;
      hand_q      <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      hand_q      <= hand_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    wr_q     <= wr_d;
    slot_q   <= slot_d;
    hit_q    <= hit_d;
    fill_q   <= fill_d;
    wb_q     <= wb_d;
    wbs_q    <= wbs_d;
    last_q   <= last_d;
  end

  assign in_ready_o         = (state_q == scct_pkg::StIdle);
  assign out_valid_o        = out_valid_q;
  assign slot_o             = slot_q;
  assign hit_o              = hit_q;
  assign fill_needed_o      = fill_q;
  assign writeback_needed_o = wb_q;
  assign writeback_sector_o = wbs_q;
  assign last_o             = last_q;

endmodule
